// ----- hdl/nfst_pkg.sv -----
`default_nettype none
package nfst_pkg;

  localparam int SLOT_COUNT_DEF  = 2048;
  localparam int HANDLE_BITS_DEF = 16;
  localparam int SEL_W           = 11;
  localparam int HANDLE_W        = 16;
  localparam int ID_W            = 32;

  localparam logic [ID_W-1:0] FREE_ID = '1;

  typedef enum logic [1:0] {
    REQ_ACQUIRE = 2'd0,
    REQ_RELEASE = 2'd1,
    REQ_LOOKUP  = 2'd2
  } req_type_t;

  typedef struct packed {
    req_type_t           req_type;
    logic [HANDLE_W-1:0] owner_handle;
    logic [ID_W-1:0]     owner_id;
    logic [SEL_W-1:0]    slot_sel;
    logic                link_held;
    logic                deleted_ok;
    logic                owner_deleted;
  } nfst_req_t;

  typedef struct packed {
    logic                ok;
    logic [SEL_W-1:0]    slot_out;
    logic [HANDLE_W-1:0] handle_out;
  } nfst_rsp_t;

endpackage
`default_nettype wire

// ----- hdl/next_fit_slot_link_table.sv -----
// flow: release and unused requests answer from idle; lookup reads the slot, then
// answers from ST_LOOK; acquire probes from the next-fit pointer to a free slot;
// throughput: one request at a time, the next accepted in the cycle its result is strobed;
// acquire probes one slot per cycle over one id port, up to SLOT_COUNT when full
// reset: synchronous; a clearing pass then marks every slot free, one slot per cycle,
// with busy high; the receiver cannot stall, done lasts one cycle
`default_nettype none
module next_fit_slot_link_table import nfst_pkg::*; #(
  parameter int SLOT_COUNT  = SLOT_COUNT_DEF,
  parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  nfst_req_t req,
  output logic      done,
  output nfst_rsp_t rsp
);

  localparam int IDX_W = $clog2(SLOT_COUNT);
  localparam int HS_W  = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W;
  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(SLOT_COUNT - 1);

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_SCAN  = 4'b0100,
    ST_LOOK  = 4'b1000
  } state_t;

  state_t            state, state_next;
  logic [IDX_W-1:0]  next_slot, next_slot_next;
  logic [IDX_W-1:0]  scan_addr, scan_addr_next;
  logic [IDX_W-1:0]  chk_addr, chk_addr_next;
  logic [IDX_W-1:0]  scan_cnt, scan_cnt_next;
  nfst_req_t         req_q;
  logic              done_next;
  nfst_rsp_t         rsp_next;

  logic              wr_en, wr_hd_en;
  logic [IDX_W-1:0]  wr_addr, rd_addr;
  logic [ID_W-1:0]   wr_id, rd_id;
  logic [HS_W-1:0]   wr_handle, rd_handle;

  logic [ID_W-1:0]   cmp_ref;
  logic              id_match;
  logic              lookup_hit;

  function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] a);
    return (a == LAST_SLOT) ? '0 : a + 1'b1;
  endfunction

  function automatic logic in_range(input logic [SEL_W-1:0] s);
    return 32'(s) < 32'(SLOT_COUNT);
  endfunction

  nfst_slot_store #(
    .SLOT_COUNT        (SLOT_COUNT),
    .HANDLE_STORE_BITS (HS_W)
  ) u_store (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_hd_en  (wr_hd_en),
    .wr_addr   (wr_addr),
    .wr_id     (wr_id),
    .wr_handle (wr_handle),
    .rd_addr   (rd_addr),
    .rd_id     (rd_id),
    .rd_handle (rd_handle)
  );

  // shared id comparator: free check while scanning, owner check on lookup
  assign cmp_ref  = (state == ST_SCAN) ? FREE_ID : req_q.owner_id;
  assign id_match = (rd_id == cmp_ref);

  assign lookup_hit = in_range(req_q.slot_sel) && (req_q.owner_id != FREE_ID) && id_match &&
                      !(!req_q.deleted_ok && req_q.owner_deleted);

  assign busy = (state != ST_IDLE);

  always_comb begin
    state_next     = state;
    next_slot_next = next_slot;
    scan_addr_next = scan_addr;
    chk_addr_next  = chk_addr;
    scan_cnt_next  = scan_cnt;
    done_next      = 1'b0;
    rsp_next       = rsp;
    rd_addr        = '0;
    wr_en          = 1'b0;
    wr_hd_en       = 1'b0;
    wr_addr        = '0;
    wr_id          = FREE_ID;
    wr_handle      = '0;
    unique case (state)
      ST_CLEAR: begin
        wr_en          = 1'b1;
        wr_addr        = scan_addr;
        scan_addr_next = wrap_inc(scan_addr);
        if (scan_addr == LAST_SLOT) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          rsp_next = '{ok: 1'b0, slot_out: req.slot_sel, handle_out: '0};
          unique case (req.req_type)
            REQ_ACQUIRE: begin
              rd_addr        = next_slot;
              chk_addr_next  = next_slot;
              scan_addr_next = wrap_inc(next_slot);
              scan_cnt_next  = '0;
              state_next     = ST_SCAN;
            end
            REQ_RELEASE: begin
              done_next = 1'b1;
              if (req.link_held && in_range(req.slot_sel)) begin
                wr_en       = 1'b1;
                wr_addr     = IDX_W'(req.slot_sel);
                rsp_next.ok = 1'b1;
              end
            end
            REQ_LOOKUP: begin
              rd_addr    = IDX_W'(req.slot_sel);
              state_next = ST_LOOK;
            end
            default: begin
              done_next = 1'b1;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (id_match) begin
          wr_en             = 1'b1;
          wr_hd_en          = 1'b1;
          wr_addr           = chk_addr;
          wr_id             = req_q.owner_id;
          wr_handle         = HS_W'(req_q.owner_handle);
          next_slot_next    = wrap_inc(chk_addr);
          rsp_next.ok       = 1'b1;
          rsp_next.slot_out = SEL_W'(chk_addr);
          done_next         = 1'b1;
          state_next        = ST_IDLE;
        end else if (scan_cnt == LAST_SLOT) begin
          // table full
          done_next  = 1'b1;
          state_next = ST_IDLE;
        end else begin
          rd_addr        = scan_addr;
          chk_addr_next  = scan_addr;
          scan_addr_next = wrap_inc(scan_addr);
          scan_cnt_next  = scan_cnt + 1'b1;
        end
      end
      ST_LOOK: begin
        done_next  = 1'b1;
        state_next = ST_IDLE;
        if (lookup_hit) begin
          rsp_next.ok         = 1'b1;
          rsp_next.handle_out = HANDLE_W'(rd_handle);
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      next_slot <= '0;
      scan_addr <= '0;
      done      <= 1'b0;
    end else begin
      state     <= state_next;
      next_slot <= next_slot_next;
      scan_addr <= scan_addr_next;
      done      <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    chk_addr <= chk_addr_next;
    scan_cnt <= scan_cnt_next;
    rsp      <= rsp_next;
    if (start && (state == ST_IDLE)) begin
      req_q <= req;
    end
  end

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobed while busy");

  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("accepted request neither started nor answered");

  a_free_claimed: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_SCAN) && (rd_id == FREE_ID)) |=> (done && rsp.ok))
    else $error("free slot found but acquire not reported");

endmodule
`default_nettype wire

// ----- hdl/nfst_slot_store.sv -----
`default_nettype none
module nfst_slot_store import nfst_pkg::*; #(
  parameter int SLOT_COUNT        = SLOT_COUNT_DEF,
  parameter int HANDLE_STORE_BITS = HANDLE_W
) (
  input  logic                                 clk,
  input  logic                                 wr_en,
  input  logic                                 wr_hd_en,
  input  logic [$clog2(SLOT_COUNT)-1:0]        wr_addr,
  input  logic [ID_W-1:0]                      wr_id,
  input  logic [HANDLE_STORE_BITS-1:0]         wr_handle,
  input  logic [$clog2(SLOT_COUNT)-1:0]        rd_addr,
  output logic [ID_W-1:0]                      rd_id,
  output logic [HANDLE_STORE_BITS-1:0]         rd_handle
);

  logic [ID_W-1:0]              id_mem     [SLOT_COUNT];
  logic [HANDLE_STORE_BITS-1:0] handle_mem [SLOT_COUNT];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      id_mem[wr_addr] <= wr_id;
    end
    rd_id <= id_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (wr_hd_en) begin
      handle_mem[wr_addr] <= wr_handle;
    end
    rd_handle <= handle_mem[rd_addr];
  end

endmodule
`default_nettype wire
